// File: hw/rtl/tccu_pkg.sv
package tccu_pkg;

  localparam int TIME_BITS   = 63;
  localparam int PERIOD_W    = 32;
  localparam int COUNT_W     = 64;
  localparam int STEP_W      = 3;
  localparam int ITER_W      = $clog2(TIME_BITS);
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = TIME_BITS;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [PERIOD_W-1:0]  period_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [STEP_W-1:0]    step_t;
  typedef logic [ITER_W-1:0]    iter_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_TICK_PERIOD = 1'b0;
  localparam cfg_idx_t CFG_START_TIME  = 1'b1;

  localparam period_t PERIOD_RESET = period_t'(10000000);

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_ELAPSED,
    OP_DIV_STEP,
    OP_COMMIT,
    OP_DEADLINE,
    OP_ZERO,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_SKIP,
    C_LT_PERIOD,
    C_DIV_MORE,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    op_e op;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic skip;
    logic lt_period;
    logic div_more;
    logic out_busy;
  } stat_t;

  localparam step_t S_IDLE     = 3'd0;
  localparam step_t S_ELAPSED  = 3'd1;
  localparam step_t S_CHECK    = 3'd2;
  localparam step_t S_DIV      = 3'd3;
  localparam step_t S_COMMIT   = 3'd4;
  localparam step_t S_DEADLINE = 3'd5;
  localparam step_t S_ZERO     = 3'd6;
  localparam step_t S_EMIT     = 3'd7;

  // Microprogram: conditional jump to target when cond holds, else next step.
  function automatic uword_t ucode_rom(step_t step);
    uword_t w;
    unique case (step)
      S_IDLE:     w = '{op: OP_ACCEPT,   cond: C_NO_INPUT,  target: S_IDLE};
      S_ELAPSED:  w = '{op: OP_ELAPSED,  cond: C_SKIP,      target: S_ZERO};
      S_CHECK:    w = '{op: OP_NONE,     cond: C_LT_PERIOD, target: S_ZERO};
      S_DIV:      w = '{op: OP_DIV_STEP, cond: C_DIV_MORE,  target: S_DIV};
      S_COMMIT:   w = '{op: OP_COMMIT,   cond: C_NEVER,     target: S_IDLE};
      S_DEADLINE: w = '{op: OP_DEADLINE, cond: C_ALWAYS,    target: S_EMIT};
      S_ZERO:     w = '{op: OP_ZERO,     cond: C_NEVER,     target: S_IDLE};
      S_EMIT:     w = '{op: OP_EMIT,     cond: C_OUT_BUSY,  target: S_EMIT};
      default:    w = '{op: OP_NONE,     cond: C_NEVER,     target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/tccu_in_if.sv
interface tccu_in_if
  import tccu_pkg::*;
;
  logic  valid;
  logic  ready;
  time_t now_ns;

  modport source (output valid, output now_ns, input ready);
  modport sink (input valid, input now_ns, output ready);
endinterface

// File: hw/rtl/tccu_out_if.sv
interface tccu_out_if
  import tccu_pkg::*;
;
  logic   valid;
  logic   ready;
  time_t  ticks_added;
  count_t tick_count;
  time_t  last_tick_time;
  time_t  next_deadline;

  modport source (
    output valid, output ticks_added, output tick_count,
    output last_tick_time, output next_deadline, input ready
  );
  modport sink (
    input valid, input ticks_added, input tick_count,
    input last_tick_time, input next_deadline, output ready
  );
endinterface

// File: hw/rtl/tccu_seq.sv
module tccu_seq
  import tccu_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  step_t  step_q, step_d;
  uword_t word;
  logic   taken;

  assign word = ucode_rom(step_q);
  assign ctrl_o.op = word.op;

  always_comb begin
    unique case (word.cond)
      C_NEVER:     taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_NO_INPUT:  taken = !stat_i.in_valid;
      C_SKIP:      taken = stat_i.skip;
      C_LT_PERIOD: taken = stat_i.lt_period;
      C_DIV_MORE:  taken = stat_i.div_more;
      C_OUT_BUSY:  taken = stat_i.out_busy;
      default:     taken = 1'b0;
    endcase
    step_d = taken ? word.target : step_q + step_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// File: hw/rtl/tccu_dp.sv
module tccu_dp
  import tccu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  cfg_idx_t         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  ctrl_t            ctrl_i,
  output stat_t            stat_o,
  tccu_in_if.sink          in_i,
  tccu_out_if.source       out_o
);

  period_t period_q;
  time_t   start_q;
  time_t   now_q;
  time_t   last_q;
  count_t  count_q;
  time_t   next_q;
  time_t   added_q;
  time_t   quo_q;
  period_t rem_q;
  iter_t   iter_q;
  logic    out_valid_q;
  time_t   out_added_q, out_last_q, out_next_q;
  count_t  out_count_q;

  logic [PERIOD_W:0]  shifted;
  logic               fits;
  logic [TIME_BITS:0] dl_sum;
  logic               in_xfer, out_xfer, out_busy;

  assign in_i.ready = (ctrl_i.op == OP_ACCEPT);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_xfer   = out_valid_q && out_o.ready;
  assign out_busy   = out_valid_q && !out_o.ready;

  // one restoring division step: remainder stays below the period
  assign shifted = {rem_q, quo_q[TIME_BITS-1]};
  assign fits    = shifted >= {1'b0, period_q};
  assign dl_sum  = {1'b0, last_q} + (TIME_BITS+1)'(period_q);

  assign stat_o.in_valid  = in_i.valid;
  assign stat_o.skip      = (period_q == '0) || (now_q < last_q);
  assign stat_o.lt_period = quo_q < time_t'(period_q);
  assign stat_o.div_more  = iter_q != iter_t'(TIME_BITS - 1);
  assign stat_o.out_busy  = out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
      start_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TICK_PERIOD: period_q <= cfg_data_i[PERIOD_W-1:0];
        CFG_START_TIME:  start_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= '0;
      count_q     <= '0;
      next_q      <= '0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.op == OP_EMIT && !out_busy) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
      unique case (ctrl_i.op)
        OP_ACCEPT: begin
          if (in_xfer && last_q == '0) begin
            last_q <= start_q;
          end
        end
        OP_ELAPSED:  iter_q <= '0;
        OP_DIV_STEP: iter_q <= iter_q + iter_t'(1);
        OP_COMMIT: begin
          // whole periods added equal elapsed minus remainder
          last_q  <= now_q - time_t'(rem_q);
          count_q <= count_q + count_t'(quo_q);
        end
        OP_DEADLINE: next_q <= dl_sum[TIME_BITS] ? '1 : dl_sum[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      OP_ACCEPT: begin
        if (in_xfer) begin
          now_q <= in_i.now_ns;
        end
      end
      OP_ELAPSED: begin
        quo_q <= now_q - last_q;
        rem_q <= '0;
      end
      OP_DIV_STEP: begin
        quo_q <= {quo_q[TIME_BITS-2:0], fits};
        rem_q <= fits ? PERIOD_W'(shifted - {1'b0, period_q}) : shifted[PERIOD_W-1:0];
      end
      OP_COMMIT: added_q <= quo_q;
      OP_ZERO:   added_q <= '0;
      OP_EMIT: begin
        if (!out_busy) begin
          out_added_q <= added_q;
          out_count_q <= count_q;
          out_last_q  <= last_q;
          out_next_q  <= next_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.ticks_added    = out_added_q;
  assign out_o.tick_count     = out_count_q;
  assign out_o.last_tick_time = out_last_q;
  assign out_o.next_deadline  = out_next_q;

endmodule

// File: hw/rtl/tick_count_catch_up_updater_core.sv
// Periodic tick counter with catch-up. Each timestamp transfer on in_i (ns)
// yields one result on out_o: whole periods elapsed since the last counted
// tick, the 64-bit running count, the last tick time and the next deadline.
// A small microprogram drives one restoring divider, one quotient bit per
// cycle. An item that counts ticks passes through the divider before its
// result; an item that counts none skips it, after a check against the
// period unless the period is zero or the time lies behind the last tick.
// Input is taken only while the program sits idle; the output register lets
// the next item start as soon as the result is handed over to it. Write
// tick_period_ns and start_time only while no item is in flight.
module tick_count_catch_up_updater_core
  import tccu_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  cfg_idx_t              cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  tccu_in_if.sink               in_i,
  tccu_out_if.source            out_o
);

  ctrl_t ctrl;
  stat_t stat;

  tccu_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  tccu_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .in_i       (in_i),
    .out_o      (out_o)
  );

endmodule

// File: bench/tick_checker.sv
`timescale 1ns / 100ps

module tick_checker
  import tccu_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  cfg_idx_t              cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  tccu_in_if                    in_mon_i,
  tccu_out_if                   out_mon_i,
  output int unsigned           results_o,
  output int unsigned           fail_o
);

  localparam time_t TIME_MAX = '1;

  typedef struct packed {
    time_t  ticks_added;
    count_t tick_count;
    time_t  last_tick_time;
    time_t  next_deadline;
  } tick_res_t;

  period_t     period_q;
  time_t       start_q;
  time_t       last_tick_q;
  count_t      tick_cnt_q;
  time_t       deadline_q;
  tick_res_t   pending_ticks[$];
  int unsigned mismatch_cnt;

  function automatic tick_res_t advance_ticks(input time_t now);
    tick_res_t   res;
    logic [63:0] span;
    logic [63:0] per;
    logic [63:0] whole;
    per  = {32'd0, period_q};
    res.ticks_added = '0;
    if (last_tick_q == '0) last_tick_q = start_q;
    if (period_q != '0 && now >= last_tick_q) begin
      span = {1'b0, now - last_tick_q};
      if (span >= per) begin
        whole       = span / per;
        // whole * per never exceeds span, so the sum stays within the time range
        last_tick_q = time_t'({1'b0, last_tick_q} + whole * per);
        tick_cnt_q  = tick_cnt_q + whole;
        res.ticks_added = time_t'(whole);
        if ({1'b0, TIME_MAX - last_tick_q} < per) deadline_q = TIME_MAX;
        else deadline_q = last_tick_q + time_t'(per);
      end
    end
    res.tick_count     = tick_cnt_q;
    res.last_tick_time = last_tick_q;
    res.next_deadline  = deadline_q;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tick_res_t want;
    if (!rst_ni) begin
      period_q     = PERIOD_RESET;
      start_q      = '0;
      last_tick_q  = '0;
      tick_cnt_q   = '0;
      deadline_q   = '0;
      pending_ticks.delete();
      mismatch_cnt = 0;
      results_o    = 0;
      fail_o       = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_TICK_PERIOD) period_q = period_t'(cfg_data_i);
        else if (cfg_idx_i == CFG_START_TIME) start_q = time_t'(cfg_data_i);
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        results_o++;
        if (pending_ticks.size() == 0) begin
          $display("%0t: result transfer with nothing expected, tick_count %0d", $time,
                   out_mon_i.tick_count);
          mismatch_cnt++;
        end else begin
          want = pending_ticks.pop_front();
          check_field("ticks_added", 64'(want.ticks_added), 64'(out_mon_i.ticks_added));
          check_field("tick_count", want.tick_count, out_mon_i.tick_count);
          check_field("last_tick_time", 64'(want.last_tick_time),
                      64'(out_mon_i.last_tick_time));
          check_field("next_deadline", 64'(want.next_deadline),
                      64'(out_mon_i.next_deadline));
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        pending_ticks.push_back(advance_ticks(in_mon_i.now_ns));
      end
      // leftover expectations count as failures once the run is over
      fail_o = mismatch_cnt + pending_ticks.size();
    end
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import tccu_pkg::*;

  localparam time_t       TIME_MAX    = '1;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned HOLD_CYCLES = 400;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  cfg_idx_t              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned results;
  int unsigned fail_cnt;
  int unsigned sent_cnt    = 0;
  int unsigned tx_idle_pct = 37;
  int unsigned rx_idle_pct = 61;
  bit          hold_req    = 1'b0;
  period_t     period_set  = PERIOD_RESET;
  time_t       stamp_hi    = '0;

  tccu_in_if  in_ch ();
  tccu_out_if out_ch ();

  tick_count_catch_up_updater_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  tick_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_mon_i   (in_ch),
    .out_mon_i  (out_ch),
    .results_o  (results),
    .fail_o     (fail_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("status: fail");
    $finish;
  end

  // result side: random stalls plus one long hold-off on request
  initial begin : result_sink
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_stamp(input time_t stamp);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.now_ns <= stamp;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sent_cnt++;
    if (stamp > stamp_hi) stamp_hi = stamp;
  endtask

  task automatic drain(input int unsigned tail);
    in_ch.valid <= 1'b0;
    while (results != sent_cnt) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  // both registers in back-to-back cycles, enable held high across them
  task automatic set_regs(input period_t per, input time_t start);
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'(per);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_TICK_PERIOD;
    cfg_data <= word;
    @(posedge clk_i);
    cfg_idx  <= CFG_START_TIME;
    cfg_data <= start;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    period_set = per;
  endtask

  function automatic period_t pick_period();
    case ($urandom_range(9))
      0:       return '0;
      1:       return period_t'(1);
      2, 3, 4: return period_t'($urandom_range(1000, 2));
      5, 6, 7: return period_t'($urandom_range(1 << 24, 1001));
      default: return period_t'($urandom);
    endcase
  endfunction

  // mostly forward steps of a few periods; some repeats and stale times
  function automatic time_t pick_stamp();
    logic [63:0] per;
    logic [63:0] hop;
    int unsigned sel;
    per = {32'd0, period_set};
    sel = $urandom_range(99);
    if (sel < 75) begin
      if (per == 0) hop = {32'd0, $urandom_range(1000)};
      else hop = per * 64'($urandom_range(40)) + {32'd0, $urandom} % per;
      return stamp_hi + time_t'(hop);
    end else if (sel < 85) begin
      return stamp_hi;
    end else if (sel < 95) begin
      return stamp_hi - time_t'($urandom_range(1 << 20, 1));
    end
    return time_t'($urandom);
  endfunction

  initial begin : stimulus
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_TICK_PERIOD;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.now_ns = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // start time zero: last tick stays at zero while nothing is counted
    send_stamp('0);
    send_stamp(time_t'(9_999_999));
    drain(4);
    set_regs(PERIOD_RESET, time_t'(1000));
    send_stamp(time_t'(500));                       // behind the loaded start time
    send_stamp(time_t'(1000 + 10_000_000 - 1));
    send_stamp(time_t'(1000 + 10_000_000));         // exactly one period
    send_stamp(time_t'(1000 + 40_000_007));         // catch up three
    send_stamp(time_t'(1000 + 40_000_007));
    drain(4);
    set_regs('0, '0);
    send_stamp(time_t'(90_000_000));
    send_stamp(time_t'(7));
    drain(4);
    set_regs(period_t'(1), TIME_MAX);
    send_stamp(time_t'(90_000_001));
    send_stamp(time_t'(90_001_000));
    send_stamp(time_t'(3));
    drain(4);
    set_regs('1, time_t'(5));
    send_stamp(time_t'(64'd90_001_000 + 64'hFFFF_FFFE));
    send_stamp(time_t'(64'd90_001_000 + 64'h2_FFFF_FFFD));
    drain(4);

    for (int m = 0; m < 3; m++) begin
      tx_idle_pct = (m == 0) ? 37 : (m == 1) ? 61 : 0;
      rx_idle_pct <= (m == 0) ? 61 : (m == 1) ? 37 : 0;
      for (int ph = 0; ph < 4; ph++) begin
        drain(4);
        set_regs(pick_period(), time_t'({$urandom, $urandom}));
        if (m == 1 && ph == 0) hold_req <= 1'b1;
        repeat (100) send_stamp(pick_stamp());
      end
    end
    drain(4);

    // top of the time range: huge catch-up, then deadline saturation
    set_regs(period_t'(1), '0);
    send_stamp(TIME_MAX - time_t'(64'h2_0000_0000));
    drain(4);
    set_regs('1, TIME_MAX);
    send_stamp(TIME_MAX - time_t'(1));
    send_stamp(TIME_MAX);
    repeat (10) send_stamp(time_t'({$urandom, $urandom}));
    repeat (5) send_stamp(TIME_MAX - time_t'($urandom));
    drain(4);
    set_regs(period_t'(1), time_t'({$urandom, $urandom}));
    send_stamp(TIME_MAX);
    send_stamp(TIME_MAX);
    repeat (10) send_stamp(time_t'({$urandom, $urandom}));
    drain(80);

    if (fail_cnt == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/tccu_pkg.sv
hw/rtl/tccu_in_if.sv
hw/rtl/tccu_out_if.sv
hw/rtl/tccu_seq.sv
hw/rtl/tccu_dp.sv
hw/rtl/tick_count_catch_up_updater_core.sv
bench/tick_checker.sv
bench/tb_top.sv
